### src/rotation_matrix_to_quaternion_core_assert.svh
// Assertion macros for the rotation matrix to quaternion core.
// Used by the top level; expects clk and rst in scope.
`ifndef ROTATION_MATRIX_TO_QUATERNION_CORE_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_CORE_ASSERT_SVH

// Check that cond implies conseq in the same cycle.
`define RMQ_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// Check that cond implies conseq in the next cycle.
`define RMQ_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

### src/rmq_pkg.sv
// Shared constants for the rotation matrix to quaternion core.
// No dependencies.
package rmq_pkg;
  localparam int FRAC_BITS_DEF = 14;
  localparam int SUM_W = 17;
  localparam int ARG_W = 33;
  localparam int BR_W = 2;

  localparam logic [BR_W-1:0] BR_TRACE = 2'd0;
  localparam logic [BR_W-1:0] BR_M00 = 2'd1;
  localparam logic [BR_W-1:0] BR_M11 = 2'd2;
  localparam logic [BR_W-1:0] BR_M22 = 2'd3;
endpackage

### src/rotation_matrix_to_quaternion_core.sv
// Rotation matrix to quaternion core (Shepperd's method), signed fixed point.
// Depends on rmq_pkg, rmq_sqrt_cell, rmq_div_cell and the assertion header.
//
// Request channel: req_valid/req_ready with the nine matrix elements m00..m22.
// Result channel: res_valid/res_ready with quat_w..quat_z, branch_taken and
// degenerate. One result per request, in order.
// A request passes through an input register, the square-root cell row (one
// root bit per cell), the input register of the division cell row (one
// quotient bit per cell, three lanes side by side) and the output register.
// Throughput: one request per cycle unless the receiver stalls; every stage
// advances together. When the receiver stalls with a result waiting, the whole
// row holds and req_ready drops; it rises again in the cycle the result is taken.
// Reset clears all valid bits; no result is pending afterwards.
// A square-root argument that is not positive gives degenerate = 1 and zero
// components, with branch_taken still naming the chosen branch.
module rotation_matrix_to_quaternion_core #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic signed [15:0] m00,
  input  logic signed [15:0] m01,
  input  logic signed [15:0] m02,
  input  logic signed [15:0] m10,
  input  logic signed [15:0] m11,
  input  logic signed [15:0] m12,
  input  logic signed [15:0] m20,
  input  logic signed [15:0] m21,
  input  logic signed [15:0] m22,
  output logic        res_valid,
  input  logic        res_ready,
  output logic signed [15:0] quat_w,
  output logic signed [15:0] quat_x,
  output logic signed [15:0] quat_y,
  output logic signed [15:0] quat_z,
  output logic [1:0]  branch_taken,
  output logic        degenerate
);
  `include "rotation_matrix_to_quaternion_core_assert.svh"

  localparam int AW = rmq_pkg::ARG_W;
  localparam int SW = rmq_pkg::SUM_W;
  localparam int SQ_N = (33 + FRAC_BITS) / 2;
  localparam int DW = SQ_N + 1;
  localparam int NW = 18 + FRAC_BITS;
  localparam logic signed [AW-1:0] ONE = AW'(1) << FRAC_BITS;
  localparam logic [NW-1:0] POS_MAX = NW'(32767);
  localparam logic [NW-1:0] NEG_MAX = NW'(32768);

  logic adv;
  assign adv = !res_valid || res_ready;
  assign req_ready = adv;

  // Branch selection and square-root argument
  logic signed [AW-1:0] e00, e11, e22, tr, arg;
  logic [rmq_pkg::BR_W-1:0] br;
  logic [2:0][SW-1:0] nv;

  always_comb begin
    e00 = AW'(m00);
    e11 = AW'(m11);
    e22 = AW'(m22);
    tr = e00 + e11 + e22;
    if (tr > 0) begin
      br = rmq_pkg::BR_TRACE;
      arg = tr + ONE;
      nv[0] = SW'(m21) - SW'(m12);
      nv[1] = SW'(m02) - SW'(m20);
      nv[2] = SW'(m10) - SW'(m01);
    end else if (m00 > m11 && m00 > m22) begin
      br = rmq_pkg::BR_M00;
      arg = ONE + e00 - e11 - e22;
      nv[0] = SW'(m21) - SW'(m12);
      nv[1] = SW'(m01) + SW'(m10);
      nv[2] = SW'(m02) + SW'(m20);
    end else if (m11 > m22) begin
      br = rmq_pkg::BR_M11;
      arg = ONE + e11 - e00 - e22;
      nv[0] = SW'(m02) - SW'(m20);
      nv[1] = SW'(m01) + SW'(m10);
      nv[2] = SW'(m12) + SW'(m21);
    end else begin
      br = rmq_pkg::BR_M22;
      arg = ONE + e22 - e00 - e11;
      nv[0] = SW'(m10) - SW'(m01);
      nv[1] = SW'(m02) + SW'(m20);
      nv[2] = SW'(m12) + SW'(m21);
    end
  end

  // Square-root row
  logic                     sq_vld [0:SQ_N];
  logic [SQ_N+1:0]          sq_rem [0:SQ_N];
  logic [SQ_N-1:0]          sq_root [0:SQ_N];
  logic [2*SQ_N-1:0]        sq_rad [0:SQ_N];
  logic [2:0][SW-1:0]       sq_n [0:SQ_N];
  logic [rmq_pkg::BR_W-1:0] sq_br [0:SQ_N];
  logic                     sq_dg [0:SQ_N];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld[0] <= 1'b0;
    end else if (adv) begin
      sq_vld[0] <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_rem[0] <= '0;
      sq_root[0] <= '0;
      sq_rad[0] <= (arg > 0) ? ((2*SQ_N)'(arg[AW-2:0]) << FRAC_BITS) : '0;
      sq_n[0] <= nv;
      sq_br[0] <= br;
      sq_dg[0] <= !(arg > 0);
    end
  end

  for (genvar i = 0; i < SQ_N; i++) begin : g_sq
    rmq_sqrt_cell #(.ROOT_W(SQ_N)) u_cell (
      .clk   (clk),
      .en    (adv),
      .rem_i (sq_rem[i]),
      .root_i(sq_root[i]),
      .rad_i (sq_rad[i]),
      .rem_o (sq_rem[i+1]),
      .root_o(sq_root[i+1]),
      .rad_o (sq_rad[i+1])
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_vld[i+1] <= 1'b0;
      end else if (adv) begin
        sq_vld[i+1] <= sq_vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_n[i+1] <= sq_n[i];
        sq_br[i+1] <= sq_br[i];
        sq_dg[i+1] <= sq_dg[i];
      end
    end
  end

  // Division row: three lanes share the divisor 2r
  logic                     dv_vld [0:NW];
  logic [DW-1:0]            dv_d [0:NW];
  logic [SQ_N-1:0]          dv_half [0:NW];
  logic [2:0]               dv_neg [0:NW];
  logic [rmq_pkg::BR_W-1:0] dv_br [0:NW];
  logic                     dv_dg [0:NW];
  logic [DW-1:0]            dv_rem [0:NW][0:2];
  logic [NW-1:0]            dv_nq [0:NW][0:2];

  logic [SQ_N-1:0] r_fin;
  assign r_fin = sq_root[SQ_N];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld[0] <= 1'b0;
    end else if (adv) begin
      dv_vld[0] <= sq_vld[SQ_N];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_d[0] <= {r_fin, 1'b0};
      dv_half[0] <= SQ_N'(({1'b0, r_fin} + 1'b1) >> 1);
      dv_br[0] <= sq_br[SQ_N];
      dv_dg[0] <= sq_dg[SQ_N];
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_prep
    logic signed [SW-1:0] ns;
    logic [SW-1:0]        mag;
    assign ns = $signed(sq_n[SQ_N][l]);
    assign mag = ns[SW-1] ? SW'(-ns) : SW'(ns);

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_neg[0][l] <= ns[SW-1];
        dv_rem[0][l] <= '0;
        dv_nq[0][l] <= (NW'(mag) << FRAC_BITS) + NW'(r_fin);
      end
    end
  end

  for (genvar i = 0; i < NW; i++) begin : g_dv
    for (genvar l = 0; l < 3; l++) begin : g_lane
      rmq_div_cell #(.NUM_W(NW), .DEN_W(DW)) u_cell (
        .clk  (clk),
        .en   (adv),
        .den  (dv_d[i]),
        .rem_i(dv_rem[i][l]),
        .nq_i (dv_nq[i][l]),
        .rem_o(dv_rem[i+1][l]),
        .nq_o (dv_nq[i+1][l])
      );
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[i+1] <= 1'b0;
      end else if (adv) begin
        dv_vld[i+1] <= dv_vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_d[i+1] <= dv_d[i];
        dv_half[i+1] <= dv_half[i];
        dv_neg[i+1] <= dv_neg[i];
        dv_br[i+1] <= dv_br[i];
        dv_dg[i+1] <= dv_dg[i];
      end
    end
  end

  // Saturate, sign and place the components
  logic [2:0][15:0] lane_q;
  logic [15:0]      half_s;
  logic [15:0]      w_n, x_n, y_n, z_n;

  for (genvar l = 0; l < 3; l++) begin : g_sat
    logic [NW-1:0] q;
    logic [NW-1:0] qn;
    assign q = dv_nq[NW][l];
    assign qn = -q;
    always_comb begin
      if (dv_neg[NW][l]) begin
        lane_q[l] = (q > NEG_MAX) ? 16'h8000 : qn[15:0];
      end else begin
        lane_q[l] = (q > POS_MAX) ? 16'h7fff : q[15:0];
      end
    end
  end

  assign half_s = (dv_half[NW] > SQ_N'(32767)) ? 16'h7fff : dv_half[NW][15:0];

  always_comb begin
    unique case (dv_br[NW])
      rmq_pkg::BR_TRACE: begin
        w_n = half_s; x_n = lane_q[0]; y_n = lane_q[1]; z_n = lane_q[2];
      end
      rmq_pkg::BR_M00: begin
        w_n = lane_q[0]; x_n = half_s; y_n = lane_q[1]; z_n = lane_q[2];
      end
      rmq_pkg::BR_M11: begin
        w_n = lane_q[0]; x_n = lane_q[1]; y_n = half_s; z_n = lane_q[2];
      end
      default: begin
        w_n = lane_q[0]; x_n = lane_q[1]; y_n = lane_q[2]; z_n = half_s;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= dv_vld[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      quat_w <= dv_dg[NW] ? '0 : w_n;
      quat_x <= dv_dg[NW] ? '0 : x_n;
      quat_y <= dv_dg[NW] ? '0 : y_n;
      quat_z <= dv_dg[NW] ? '0 : z_n;
      branch_taken <= dv_br[NW];
      degenerate <= dv_dg[NW];
    end
  end

  `RMQ_ASSERT_NOW(a_degen_zero, res_valid && degenerate,
    quat_w == 16'd0 && quat_x == 16'd0 && quat_y == 16'd0 && quat_z == 16'd0,
    "degenerate result carries nonzero components")
  `RMQ_ASSERT_NOW(a_trace_ok, res_valid && branch_taken == rmq_pkg::BR_TRACE,
    !degenerate, "trace branch flagged degenerate")
  `RMQ_ASSERT_NEXT(a_hold, res_valid && !res_ready, res_valid && $stable(quat_w),
    "stalled result lost")
endmodule

### src/rmq_sqrt_cell.sv
// One step of the digit-by-digit square root: one root bit per cell.
// Uses no package items.
module rmq_sqrt_cell #(
  parameter int ROOT_W = 23
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [ROOT_W+1:0]     rem_i,
  input  logic [ROOT_W-1:0]     root_i,
  input  logic [2*ROOT_W-1:0]   rad_i,
  output logic [ROOT_W+1:0]     rem_o,
  output logic [ROOT_W-1:0]     root_o,
  output logic [2*ROOT_W-1:0]   rad_o
);
  logic [ROOT_W+1:0] rem_s;
  logic [ROOT_W+1:0] trial;
  logic              ge;

  assign rem_s = {rem_i[ROOT_W-1:0], rad_i[2*ROOT_W-1 -: 2]};
  assign trial = {root_i, 2'b01};
  assign ge = rem_s >= trial;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o <= ge ? rem_s - trial : rem_s;
      root_o <= {root_i[ROOT_W-2:0], ge};
      rad_o <= {rad_i[2*ROOT_W-3:0], 2'b00};
    end
  end
endmodule

### src/rmq_div_cell.sv
// One step of restoring division: one quotient bit per cell.
// Uses no package items.
module rmq_div_cell #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 24
) (
  input  logic             clk,
  input  logic             en,
  input  logic [DEN_W-1:0] den,
  input  logic [DEN_W-1:0] rem_i,
  input  logic [NUM_W-1:0] nq_i,
  output logic [DEN_W-1:0] rem_o,
  output logic [NUM_W-1:0] nq_o
);
  logic [DEN_W:0] rem_s;
  logic [DEN_W:0] diff;
  logic           ge;

  assign rem_s = {rem_i, nq_i[NUM_W-1]};
  assign ge = rem_s >= {1'b0, den};
  assign diff = rem_s - {1'b0, den};

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o <= ge ? diff[DEN_W-1:0] : rem_s[DEN_W-1:0];
      nq_o <= {nq_i[NUM_W-2:0], ge};
    end
  end
endmodule

### tb/testbench.sv
// Testbench for rotation_matrix_to_quaternion_core: directed and random matrices,
// checked against an in-bench fixed-point Shepperd predictor.
// Depends on rmq_pkg and the core RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = rmq_pkg::FRAC_BITS_DEF;
  localparam int LATENCY = 57;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic signed [15:0] w, x, y, z;
    logic [rmq_pkg::BR_W-1:0] br;
    logic degen;
  } quat_t;

  logic clk = 0;
  logic rst = 1;
  logic req_valid = 0;
  logic req_ready;
  logic signed [15:0] m00 = 0, m01 = 0, m02 = 0, m10 = 0, m11 = 0, m12 = 0;
  logic signed [15:0] m20 = 0, m21 = 0, m22 = 0;
  logic res_valid;
  logic res_ready = 0;
  logic signed [15:0] quat_w, quat_x, quat_y, quat_z;
  logic [1:0] branch_taken;
  logic degenerate;

  quat_t expected_quats[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  rotation_matrix_to_quaternion_core uut (.*);

  function automatic longint root_floor(longint v);
    longint lo, hi, mid;
    lo = 0;
    hi = 64'sd3037000499;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid <= v) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic longint round_div(longint n, longint den);
    longint mag, q;
    mag = (n < 0 ? -n : n) <<< FB;
    q = (2 * mag + den) / (2 * den);
    return n < 0 ? -q : q;
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  function automatic quat_t shepperd_quat(logic signed [15:0] e[9]);
    quat_t q;
    longint a, b, c, d, e1, f, g, h, i, one, tr, arg, r, half, comp[4];
    longint num[3];
    int j;
    a = longint'(e[0]); b = longint'(e[1]); c = longint'(e[2]);
    d = longint'(e[3]); e1 = longint'(e[4]); f = longint'(e[5]);
    g = longint'(e[6]); h = longint'(e[7]); i = longint'(e[8]);
    one = longint'(1) <<< FB;
    tr = a + e1 + i;
    if (tr > 0) begin
      q.br = rmq_pkg::BR_TRACE; arg = tr + one;
      num[0] = h - f; num[1] = c - g; num[2] = d - b;
    end else if (a > e1 && a > i) begin
      q.br = rmq_pkg::BR_M00; arg = one + a - e1 - i;
      num[0] = h - f; num[1] = b + d; num[2] = c + g;
    end else if (e1 > i) begin
      q.br = rmq_pkg::BR_M11; arg = one + e1 - a - i;
      num[0] = c - g; num[1] = b + d; num[2] = f + h;
    end else begin
      q.br = rmq_pkg::BR_M22; arg = one + i - a - e1;
      num[0] = d - b; num[1] = c + g; num[2] = f + h;
    end
    q.degen = 0;
    comp = '{0, 0, 0, 0};
    if (arg <= 0) q.degen = 1;
    else begin
      r = root_floor(arg <<< FB);
      if (r == 0) q.degen = 1;
      else begin
        half = (r + 1) >>> 1;
        j = 0;
        for (int k = 0; k < 4; k++) begin
          if (k == int'(q.br)) comp[k] = half;
          else begin
            comp[k] = round_div(num[j], 2 * r);
            j++;
          end
        end
      end
    end
    q.w = q.degen ? 16'sd0 : clamp16(comp[0]);
    q.x = q.degen ? 16'sd0 : clamp16(comp[1]);
    q.y = q.degen ? 16'sd0 : clamp16(comp[2]);
    q.z = q.degen ? 16'sd0 : clamp16(comp[3]);
    return q;
  endfunction

  task automatic send_request(logic signed [15:0] e[9]);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    {m00, m01, m02, m10, m11, m12, m20, m21, m22} <=
      {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    expected_quats.push_back(shepperd_quat(e));
  endtask

  task automatic send_matrix(int v[9]);
    logic signed [15:0] e[9];
    foreach (e[k]) e[k] = 16'(v[k]);
    send_request(e);
  endtask

  function automatic logic signed [15:0] rand_elem(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'(int'($urandom_range(32767, 0)) - 16384);
      2: return 16'(int'($urandom_range(18000, 0)) - 9000);
      default: return $urandom_range(2) == 0 ? -16'sd32768 :
                      ($urandom_range(1) ? 16'sd32767 : 16'sd0);
    endcase
  endfunction

  task automatic send_random(int n);
    logic signed [15:0] e[9];
    real ang, cs, sn;
    int ax, mode;
    for (int t = 0; t < n; t++) begin
      mode = int'($urandom_range(9));
      if (mode < 6) begin
        ang = ($urandom_range(62831) / 10000.0);
        cs = $cos(ang); sn = $sin(ang);
        ax = int'($urandom_range(2));
        foreach (e[k]) e[k] = 16'(int'($urandom_range(6)) - 3);
        e[4 * ax] = 16'sd16384;
        for (int p = 0; p < 3; p++) if (p != ax) e[4 * p] = 16'($rtoi(cs * 16384));
        case (ax)
          0: begin e[5] = 16'(-$rtoi(sn * 16384)); e[7] = 16'($rtoi(sn * 16384)); end
          1: begin e[2] = 16'($rtoi(sn * 16384)); e[6] = 16'(-$rtoi(sn * 16384)); end
          default: begin
            e[1] = 16'(-$rtoi(sn * 16384)); e[3] = 16'($rtoi(sn * 16384));
          end
        endcase
      end else foreach (e[k]) e[k] = rand_elem(mode - 6);
      send_request(e);
    end
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    while (expected_quats.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_matrix('{16384, 0, 0, 0, 16384, 0, 0, 0, 16384});
    send_matrix('{16384, 0, 0, 0, -16384, 0, 0, 0, -16384});
    send_matrix('{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384});
    send_matrix('{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384});
    send_matrix('{0, 0, 0, 0, 0, 0, 0, 0, 0});
    send_matrix('{5, 1, 2, 3, 5, 4, 6, 7, -10});
    send_matrix('{-5, 1, 2, 3, -5, 4, 6, 7, -5});
    send_matrix('{-20000, 9, 9, 9, -20000, 9, 9, 9, -20000});
    send_matrix('{-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768});
    send_matrix('{-32768, -32768, 32767, 32767, 32767, -32768, -32768, 32767, 32767});
    send_matrix('{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767});
    send_matrix('{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768});
    send_matrix('{32767, -32768, 32767, -32768, -32768, 32767, -32768, 32767, -32768});
    send_matrix('{-32768, 32767, 32767, -32768, -32768, -32768, 32767, 32767, 32767});
    send_matrix('{0, -1, 0, 1, -1, 0, 0, 0, -1});
    send_matrix('{-1, 0, 0, 0, -1, 0, 0, 0, 1});
    send_matrix('{-16384, -32768, 0, 32767, -16385, 0, 0, 0, 1});
    send_matrix('{-16384, 3, 0, 0, -16384, 0, 0, 0, -16383});
    wait_drained();
  endtask

  task automatic test_idling();
    int pct[4][2] = '{'{0, 0}, '{48, 0}, '{0, 48}, '{36, 36}};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = pct[p][0];
      recv_stall_pct = pct[p][1];
      send_random(340);
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_cycles = 150;
    send_random(100);
    wait_drained();
    send_random(10);
  endtask

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      res_ready <= 0;
    end else res_ready <= rst ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    quat_t q;
    if (!rst && res_valid && res_ready) begin
      if (expected_quats.size() == 0) begin
        $error("result with no request pending");
        errors++;
      end else begin
        q = expected_quats.pop_front();
        if (quat_w !== q.w) begin $error("quat_w exp %0d got %0d", q.w, quat_w); errors++; end
        if (quat_x !== q.x) begin $error("quat_x exp %0d got %0d", q.x, quat_x); errors++; end
        if (quat_y !== q.y) begin $error("quat_y exp %0d got %0d", q.y, quat_y); errors++; end
        if (quat_z !== q.z) begin $error("quat_z exp %0d got %0d", q.z, quat_z); errors++; end
        if (branch_taken !== q.br) begin
          $error("branch_taken exp %0d got %0d", q.br, branch_taken); errors++;
        end
        if (degenerate !== q.degen) begin
          $error("degenerate exp %0d got %0d", q.degen, degenerate); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((req_valid && req_ready) || (res_valid && res_ready) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_idling();
    test_backpressure();
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && expected_quats.size() == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end
endmodule

### filelist.f
+incdir+src
src/rmq_pkg.sv
src/rmq_sqrt_cell.sv
src/rmq_div_cell.sv
src/rotation_matrix_to_quaternion_core.sv
tb/testbench.sv
